>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the encoder; NO_ASSERTIONS compiles them
// out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// General property, checked at every rising clock edge outside reset
`define PFE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset
`define PFE_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define PFE_ASSERT(lbl, clk, rst, prop, msg)
`define PFE_ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

>>> hdl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared constants, types and symbol helpers of the 6x6 square encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfe_pkg;

   localparam int SQUARE_SIDE  = 6;
   localparam int CELL_COUNT   = SQUARE_SIDE * SQUARE_SIDE;
   localparam int LETTER_COUNT = 26;
   localparam int SYM_W        = $clog2(CELL_COUNT);

   // floor(x / 6) == (x * 43) >> 8 for every x below 64
   localparam logic [11:0] ROW_RECIP = 12'd43;
   localparam int          ROW_SHIFT = 8;

   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_X = 8'h58;
   localparam logic [7:0] CASE_GAP   = 8'h20;

   localparam logic [1:0] KIND_KEY_CHAR = 2'd0;
   localparam logic [1:0] KIND_KEY_END  = 2'd1;
   localparam logic [1:0] KIND_MSG_CHAR = 2'd2;
   localparam logic [1:0] KIND_MSG_END  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_SQUARE,
      ST_LOAD
   } state_type;

   // Placement write into both square memories
   typedef struct packed {
      logic             en;
      logic [SYM_W-1:0] sym;
      logic [SYM_W-1:0] slot;
   } sq_wr_type;

   // Two-step pair lookup
   typedef struct packed {
      logic             cells_rd;
      logic [SYM_W-1:0] sym_a;
      logic [SYM_W-1:0] sym_b;
      logic             square_rd;
   } sq_rd_type;

   function automatic logic is_symbol(input logic [7:0] ch);
      return (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) || (ch >= CH_ZERO && ch <= CH_NINE);
   endfunction

   function automatic logic [SYM_W-1:0] symbol_of(input logic [7:0] ch);
      logic [7:0] tmp;
      if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
         tmp = ch - CH_UPPER_A;
      end else begin
         tmp = ch - CH_ZERO + 8'(LETTER_COUNT);
      end
      return tmp[SYM_W-1:0];
   endfunction

   function automatic logic [7:0] ascii_of(input logic [SYM_W-1:0] sym);
      logic [7:0] wide;
      wide = {{(8-SYM_W){1'b0}}, sym};
      if (wide < 8'(LETTER_COUNT)) begin
         return CH_UPPER_A + wide;
      end
      return CH_ZERO + (wide - 8'(LETTER_COUNT));
   endfunction

   function automatic logic [7:0] fold_upper(input logic [7:0] ch);
      if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
         return ch - CASE_GAP;
      end
      return ch;
   endfunction

   function automatic logic [2:0] row_of(input logic [SYM_W-1:0] slot);
      logic [11:0] prod;
      prod = {{(12-SYM_W){1'b0}}, slot} * ROW_RECIP;
      return prod[ROW_SHIFT+2:ROW_SHIFT];
   endfunction

   function automatic logic [2:0] col_of(input logic [SYM_W-1:0] slot);
      logic [SYM_W-1:0] base;
      base = SYM_W'(row_of(slot)) * SYM_W'(SQUARE_SIDE);
      return 3'(slot - base);
   endfunction

   function automatic logic [SYM_W-1:0] cell_at(input logic [2:0] row, input logic [2:0] col);
      return SYM_W'(row) * SYM_W'(SQUARE_SIDE) + SYM_W'(col);
   endfunction

endpackage

>>> hdl/playfair_6x6_encoder_core.sv
// ----------------------------------------------------------------------------
// playfair_6x6_encoder_core
// Builds a 6x6 key square over A-Z and 0-9 and encrypts message symbols in
// pairs by the rectangle rule.
// ----------------------------------------------------------------------------
//
//   channel   ports                               direction
//   request   req_valid req_stall req_kind
//             req_char_code                       in  (stall out)
//   response  rsp_valid rsp_stall rsp_cipher_char
//             rsp_last_of_pair                    out (stall in)
//
// Key characters, unpaired message characters and message ends with nothing
// pending are taken in the idle state. After a key end the placement logic
// walks every symbol once. A request that completes a pair holds the request
// side through cell lookup, square lookup (both synchronous memory reads),
// then load of the 2-entry response register, which waits until the
// previous pair has drained.
// Reset (synchronous, active high) clears the used bits, fill count, pairing
// state and response register; the memories need no clearing.
// A stalled response holds; the next pair's lookup runs behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module playfair_6x6_encoder_core (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_char_code,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_cipher_char,
   output logic       rsp_last_of_pair
);

   localparam int SW = pfe_pkg::SYM_W;
   localparam logic [SW-1:0] LAST_SYM = SW'(pfe_pkg::CELL_COUNT - 1);
   localparam logic [SW-1:0] FULL_CNT = SW'(pfe_pkg::CELL_COUNT);

   pfe_pkg::state_type state_ff, state_in;

   // ---------------- key square bookkeeping ----------------
   logic [pfe_pkg::CELL_COUNT-1:0] used_ff, used_in;
   logic [SW-1:0] filled_ff, filled_in;
   logic [SW-1:0] fill_sym_ff, fill_sym_in;

   // ---------------- pairing state ----------------
   logic          pending_ff, pending_in;
   logic [SW-1:0] pending_sym_ff, pending_sym_in;
   logic [SW-1:0] a_ff, a_in;
   logic [SW-1:0] b_ff, b_in;
   logic          ok_ff, ok_in;

   // ---------------- response register ----------------
   logic [1:0] out_cnt_ff, out_cnt_in;
   logic [7:0] out_c0_ff, out_c0_in;
   logic [7:0] out_c1_ff, out_c1_in;

   logic req_acc;
   logic rsp_acc;
   logic is_key_char, is_key_end, is_msg_char, is_msg_end;
   logic [7:0] msg_ch;
   logic key_ok, msg_ok;
   logic [SW-1:0] key_sym, msg_sym, partner;
   logic start_enc;
   logic fill_active, square_rd, load_ready;
   logic [SW-1:0] place_sym;
   logic place_req, do_place;
   logic load_out;

   pfe_pkg::sq_wr_type sq_wr;
   pfe_pkg::sq_rd_type sq_rd;
   logic [SW-1:0] sq_a, sq_b;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   always_comb begin
      is_key_char = 1'b0;
      is_key_end  = 1'b0;
      is_msg_char = 1'b0;
      is_msg_end  = 1'b0;
      unique case (req_kind)
         pfe_pkg::KIND_KEY_CHAR: is_key_char = 1'b1;
         pfe_pkg::KIND_KEY_END:  is_key_end  = 1'b1;
         pfe_pkg::KIND_MSG_CHAR: is_msg_char = 1'b1;
         pfe_pkg::KIND_MSG_END:  is_msg_end  = 1'b1;
         default: ;
      endcase
   end

   // Key characters must already be upper case; message characters are folded
   assign key_ok  = pfe_pkg::is_symbol(req_char_code);
   assign key_sym = pfe_pkg::symbol_of(req_char_code);
   assign msg_ch  = pfe_pkg::fold_upper(req_char_code);
   assign msg_ok  = pfe_pkg::is_symbol(msg_ch);
   assign msg_sym = pfe_pkg::symbol_of(msg_ch);

   // Message end pads a leftover symbol with X
   assign partner = is_msg_end ? pfe_pkg::symbol_of(pfe_pkg::CH_UPPER_X) : msg_sym;

   assign start_enc = req_acc && pending_ff && ((is_msg_char && msg_ok) || is_msg_end);

   // ---------------- state machine ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfe_pkg::ST_IDLE: begin
            if (req_acc && is_key_end) begin
               state_in = pfe_pkg::ST_FILL;
            end else if (start_enc) begin
               state_in = pfe_pkg::ST_SQUARE;
            end
         end
         pfe_pkg::ST_FILL: begin
            if (fill_sym_ff == LAST_SYM) begin
               state_in = pfe_pkg::ST_IDLE;
            end
         end
         pfe_pkg::ST_SQUARE: begin
            state_in = pfe_pkg::ST_LOAD;
         end
         pfe_pkg::ST_LOAD: begin
            if (out_cnt_ff == 2'd0) begin
               state_in = pfe_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      fill_active = 1'b0;
      square_rd   = 1'b0;
      load_ready  = 1'b0;
      unique case (state_ff)
         pfe_pkg::ST_IDLE:   req_stall   = 1'b0;
         pfe_pkg::ST_FILL:   fill_active = 1'b1;
         pfe_pkg::ST_SQUARE: square_rd   = 1'b1;
         pfe_pkg::ST_LOAD:   load_ready  = 1'b1;
      endcase
   end

   // ---------------- placement ----------------
   // One placement port shared by key characters and the key-end walk
   assign place_sym = fill_active ? fill_sym_ff : key_sym;
   assign place_req = fill_active || (req_acc && is_key_char && key_ok);
   assign do_place  = place_req && !used_ff[place_sym] && (filled_ff < FULL_CNT);

   always_comb begin
      used_in     = used_ff;
      filled_in   = filled_ff;
      fill_sym_in = fill_sym_ff;
      if (do_place) begin
         used_in[place_sym] = 1'b1;
         filled_in          = filled_ff + SW'(1);
      end
      if (req_acc && is_key_end) begin
         fill_sym_in = '0;
      end else if (fill_active) begin
         fill_sym_in = fill_sym_ff + SW'(1);
      end
   end

   assign sq_wr.en   = do_place;
   assign sq_wr.sym  = place_sym;
   assign sq_wr.slot = filled_ff;

   // ---------------- pairing ----------------
   always_comb begin
      pending_in     = pending_ff;
      pending_sym_in = pending_sym_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      ok_in          = ok_ff;
      if (req_acc && is_msg_char && msg_ok && !pending_ff) begin
         pending_in     = 1'b1;
         pending_sym_in = msg_sym;
      end
      if (start_enc) begin
         pending_in = 1'b0;
         a_in       = pending_sym_ff;
         b_in       = partner;
         // identical symbols or an unplaced symbol pass through unchanged
         ok_in      = (pending_sym_ff != partner) && used_ff[pending_sym_ff]
                      && used_ff[partner];
      end
   end

   assign sq_rd.cells_rd  = start_enc;
   assign sq_rd.sym_a     = pending_sym_ff;
   assign sq_rd.sym_b     = partner;
   assign sq_rd.square_rd = square_rd;

   pfe_square u_square (
      .clock (clock),
      .wr    (sq_wr),
      .rd    (sq_rd),
      .sq_a  (sq_a),
      .sq_b  (sq_b)
   );

   // ---------------- response register ----------------
   assign load_out = load_ready && (out_cnt_ff == 2'd0);

   always_comb begin
      out_cnt_in = out_cnt_ff;
      out_c0_in  = out_c0_ff;
      out_c1_in  = out_c1_ff;
      if (load_out) begin
         out_cnt_in = 2'd2;
         out_c0_in  = pfe_pkg::ascii_of(ok_ff ? sq_a : a_ff);
         out_c1_in  = pfe_pkg::ascii_of(ok_ff ? sq_b : b_ff);
      end else if (rsp_acc) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   assign rsp_valid        = (out_cnt_ff != 2'd0);
   assign rsp_cipher_char  = (out_cnt_ff == 2'd2) ? out_c0_ff : out_c1_ff;
   assign rsp_last_of_pair = (out_cnt_ff == 2'd1);

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pfe_pkg::ST_IDLE;
         used_ff        <= '0;
         filled_ff      <= '0;
         fill_sym_ff    <= '0;
         pending_ff     <= 1'b0;
         pending_sym_ff <= '0;
         out_cnt_ff     <= 2'd0;
      end else begin
         state_ff       <= state_in;
         used_ff        <= used_in;
         filled_ff      <= filled_in;
         fill_sym_ff    <= fill_sym_in;
         pending_ff     <= pending_in;
         pending_sym_ff <= pending_sym_in;
         out_cnt_ff     <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      ok_ff     <= ok_in;
      out_c0_ff <= out_c0_in;
      out_c1_ff <= out_c1_in;
   end

   // ---------------- assertions ----------------
   `PFE_ASSERT_NEVER(a_fill_bound, clock, reset, filled_ff > FULL_CNT,
                     "fill count past square size")
   `PFE_ASSERT(a_used_count, clock, reset, $countones(used_ff) == int'(filled_ff),
               "used bits disagree with fill count")
   `PFE_ASSERT(a_pad_starts, clock, reset,
               (req_acc && is_msg_end && pending_ff) |=> (state_ff == pfe_pkg::ST_SQUARE),
               "message end with leftover did not start lookup")
   `PFE_ASSERT(a_pair_order, clock, reset,
               (rsp_acc && out_cnt_ff == 2'd2) |=> (rsp_valid && rsp_last_of_pair),
               "second pair character missing")

endmodule

>>> hdl/pfe_square.sv
// ----------------------------------------------------------------------------
// pfe_square
// Key square and symbol-to-cell memories with the two-step rectangle lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfe_square (
   input  logic                        clock,
   input  pfe_pkg::sq_wr_type          wr,
   input  pfe_pkg::sq_rd_type          rd,
   output logic [pfe_pkg::SYM_W-1:0]   sq_a,
   output logic [pfe_pkg::SYM_W-1:0]   sq_b
);

   logic [pfe_pkg::SYM_W-1:0] square_mem [pfe_pkg::CELL_COUNT];
   logic [pfe_pkg::SYM_W-1:0] cells_mem  [pfe_pkg::CELL_COUNT];

   logic [pfe_pkg::SYM_W-1:0] cell_a_ff;
   logic [pfe_pkg::SYM_W-1:0] cell_b_ff;
   logic [pfe_pkg::SYM_W-1:0] sq_a_ff;
   logic [pfe_pkg::SYM_W-1:0] sq_b_ff;
   logic [pfe_pkg::SYM_W-1:0] addr_a;
   logic [pfe_pkg::SYM_W-1:0] addr_b;

   // corners: (row of a, col of b) and (row of b, col of a)
   assign addr_a = pfe_pkg::cell_at(pfe_pkg::row_of(cell_a_ff), pfe_pkg::col_of(cell_b_ff));
   assign addr_b = pfe_pkg::cell_at(pfe_pkg::row_of(cell_b_ff), pfe_pkg::col_of(cell_a_ff));

   always_ff @(posedge clock) begin
      if (wr.en) begin
         square_mem[wr.slot] <= wr.sym;
         cells_mem[wr.sym]   <= wr.slot;
      end
      if (rd.cells_rd) begin
         cell_a_ff <= cells_mem[rd.sym_a];
         cell_b_ff <= cells_mem[rd.sym_b];
      end
      if (rd.square_rd) begin
         sq_a_ff <= square_mem[addr_a];
         sq_b_ff <= square_mem[addr_b];
      end
   end

   assign sq_a = sq_a_ff;
   assign sq_b = sq_b_ff;

endmodule
